// ----- design/lmtc_pkg.sv -----
// Package: item types, register map, mode codes and timing constants of the LCD timing block.
`timescale 1ns / 1ps

package lmtc_pkg;

    localparam int unsigned ACCUM_W = 17;

    localparam logic [ACCUM_W-1:0] FRAME_CLOCKS  = 17'd70224;
    localparam logic [ACCUM_W-1:0] OAM_CLOCKS    = 17'd80;
    localparam logic [ACCUM_W-1:0] DRAW_CLOCKS   = 17'd172;
    localparam logic [ACCUM_W-1:0] HBLANK_CLOCKS = 17'd204;
    localparam logic [ACCUM_W-1:0] LINE_CLOCKS   = 17'd456;
    localparam logic [ACCUM_W-1:0] ACCUM_MAX     = 17'h1FFFF;

    localparam logic [7:0] VBLANK_FIRST = 8'd144;
    localparam logic [7:0] LAST_LINE    = 8'd153;

    localparam logic [7:0] LCDC_RESET = 8'h91;
    localparam logic [7:0] STAT_RESET = 8'h02;
    localparam logic [7:0] STAT_WMASK = 8'hF8;
    localparam logic [7:0] UNMAPPED_RD = 8'hFF;

    // STAT and LCDC bit positions
    localparam int unsigned STAT_COIN_BIT    = 2;
    localparam int unsigned STAT_HBL_IE_BIT  = 3;
    localparam int unsigned STAT_VBL_IE_BIT  = 4;
    localparam int unsigned STAT_OAM_IE_BIT  = 5;
    localparam int unsigned STAT_LYC_IE_BIT  = 6;
    localparam int unsigned LCDC_ON_BIT      = 7;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [3:0] OFS_LCDC = 4'd0;
    localparam logic [3:0] OFS_STAT = 4'd1;
    localparam logic [3:0] OFS_SCY  = 4'd2;
    localparam logic [3:0] OFS_SCX  = 4'd3;
    localparam logic [3:0] OFS_LY   = 4'd4;
    localparam logic [3:0] OFS_LYC  = 4'd5;
    localparam logic [3:0] OFS_BGP  = 4'd7;
    localparam logic [3:0] OFS_OBP0 = 4'd8;
    localparam logic [3:0] OFS_OBP1 = 4'd9;
    localparam logic [3:0] OFS_WY   = 4'd10;
    localparam logic [3:0] OFS_WX   = 4'd11;

    localparam int unsigned PLAIN_DEPTH = 7;
    localparam int unsigned PLAIN_IDX_W = $clog2(PLAIN_DEPTH);

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] clocks;
        logic [3:0] reg_offset;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       frame_ready;
        logic       stat_irq_raised;
        logic       render_line;
        logic [1:0] mode_now;
        logic [7:0] line_now;
    } t_out_item;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         line;
        logic [7:0]         stat;
        logic [ACCUM_W-1:0] accum;
    } t_timing_state;

    typedef struct packed {
        logic frame;
        logic irq;
        logic render;
    } t_tick_flags;

    typedef struct packed {
        logic                   hit;
        logic [PLAIN_IDX_W-1:0] idx;
    } t_plain_slot;

    function automatic t_plain_slot f_plain_slot(input logic [3:0] offset);
        t_plain_slot s;
        s.hit = 1'b1;
        s.idx = '0;
        unique case (offset)
            OFS_SCY:  s.idx = PLAIN_IDX_W'(0);
            OFS_SCX:  s.idx = PLAIN_IDX_W'(1);
            OFS_BGP:  s.idx = PLAIN_IDX_W'(2);
            OFS_OBP0: s.idx = PLAIN_IDX_W'(3);
            OFS_OBP1: s.idx = PLAIN_IDX_W'(4);
            OFS_WY:   s.idx = PLAIN_IDX_W'(5);
            OFS_WX:   s.idx = PLAIN_IDX_W'(6);
            default:  s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

// ----- design/lmtc_stream_if.sv -----
// Valid/ready stream interface carrying one payload per transaction.
`timescale 1ns / 1ps

interface lmtc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/lmtc_timing.sv -----
// Next-state logic of the mode/line sequencer and the display-off frame counter for one tick.
`timescale 1ns / 1ps

module lmtc_timing import lmtc_pkg::*; (
    input  t_timing_state i_state,
    input  logic          i_display_on,
    input  logic [7:0]    i_lyc,
    input  logic [7:0]    i_clocks,
    output t_timing_state o_state,
    output t_tick_flags   o_flags
);

    logic [ACCUM_W:0]   sum;
    logic [ACCUM_W-1:0] sat;
    logic [ACCUM_W-1:0] thr;
    logic [ACCUM_W-1:0] diff;
    logic               ge;
    logic [7:0]         line_inc;

    always_comb begin
        sum = {1'b0, i_state.accum} + (ACCUM_W+1)'(i_clocks);
        sat = sum[ACCUM_W] ? ACCUM_MAX : sum[ACCUM_W-1:0];

        if (!i_display_on) begin
            thr = FRAME_CLOCKS;
        end else begin
            unique case (i_state.mode)
                MODE_OAM:    thr = OAM_CLOCKS;
                MODE_DRAW:   thr = DRAW_CLOCKS;
                MODE_HBLANK: thr = HBLANK_CLOCKS;
                default:     thr = LINE_CLOCKS;
            endcase
        end

        ge       = (sat >= thr);
        diff     = sat - thr;
        line_inc = i_state.line + 8'd1;

        o_state       = i_state;
        o_state.accum = ge ? diff : sat;
        o_flags       = '0;

        if (!i_display_on) begin
            o_flags.frame = ge;
        end else if (ge) begin
            unique case (i_state.mode)
                MODE_OAM: begin
                    o_state.mode      = MODE_DRAW;
                    o_state.stat[1:0] = MODE_DRAW;
                end
                MODE_DRAW: begin
                    o_state.mode      = MODE_HBLANK;
                    o_state.stat[1:0] = MODE_HBLANK;
                    o_flags.render    = 1'b1;
                    o_flags.irq       = i_state.stat[STAT_HBL_IE_BIT];
                end
                MODE_HBLANK: begin
                    o_state.line = line_inc;
                    o_state.stat[STAT_COIN_BIT] = (line_inc == i_lyc);
                    if (line_inc == VBLANK_FIRST) begin
                        o_state.mode      = MODE_VBLANK;
                        o_state.stat[1:0] = MODE_VBLANK;
                        o_flags.frame     = 1'b1;
                        o_flags.irq       = i_state.stat[STAT_VBL_IE_BIT];
                    end else begin
                        o_state.mode      = MODE_OAM;
                        o_state.stat[1:0] = MODE_OAM;
                        o_flags.irq       = i_state.stat[STAT_OAM_IE_BIT];
                    end
                    if ((line_inc == i_lyc) && i_state.stat[STAT_LYC_IE_BIT]) begin
                        o_flags.irq = 1'b1;
                    end
                end
                default: begin
                    if (line_inc > LAST_LINE) begin
                        o_state.line      = 8'd0;
                        o_state.mode      = MODE_OAM;
                        o_state.stat[1:0] = MODE_OAM;
                        o_flags.irq       = i_state.stat[STAT_OAM_IE_BIT];
                    end else begin
                        o_state.line = line_inc;
                    end
                end
            endcase
        end
    end

endmodule

// ----- design/lmtc_regs.sv -----
// Register file and timing state; applies one tick, read or write per step.
`timescale 1ns / 1ps

module lmtc_regs import lmtc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [7:0]         r_lcdc, n_lcdc;
    logic [7:0]         r_stat, n_stat;
    logic [7:0]         r_line, n_line;
    logic [7:0]         r_lyc, n_lyc;
    logic [1:0]         r_mode, n_mode;
    logic [ACCUM_W-1:0] r_accum, n_accum;
    logic [7:0]         r_plain [PLAIN_DEPTH];
    logic [7:0]         n_plain [PLAIN_DEPTH];

    t_timing_state cur_state;
    t_timing_state tick_state;
    t_tick_flags   tick_flags;
    t_plain_slot   slot;
    logic [7:0]    rd_data;

    assign cur_state = '{mode: r_mode, line: r_line, stat: r_stat, accum: r_accum};

    lmtc_timing u_timing (
        .i_state      (cur_state),
        .i_display_on (r_lcdc[LCDC_ON_BIT]),
        .i_lyc        (r_lyc),
        .i_clocks     (i_item.clocks),
        .o_state      (tick_state),
        .o_flags      (tick_flags)
    );

    assign slot = f_plain_slot(i_item.reg_offset);

    always_comb begin
        unique case (i_item.reg_offset)
            OFS_LCDC: rd_data = r_lcdc;
            OFS_STAT: rd_data = r_stat;
            OFS_LY:   rd_data = r_line;
            OFS_LYC:  rd_data = r_lyc;
            default:  rd_data = slot.hit ? r_plain[slot.idx] : UNMAPPED_RD;
        endcase
    end

    always_comb begin
        n_lcdc  = r_lcdc;
        n_stat  = r_stat;
        n_line  = r_line;
        n_lyc   = r_lyc;
        n_mode  = r_mode;
        n_accum = r_accum;
        n_plain = r_plain;
        o_result = '0;

        unique case (i_item.command)
            CMD_TICK: begin
                n_stat  = tick_state.stat;
                n_line  = tick_state.line;
                n_mode  = tick_state.mode;
                n_accum = tick_state.accum;
                o_result.frame_ready     = tick_flags.frame;
                o_result.stat_irq_raised = tick_flags.irq;
                o_result.render_line     = tick_flags.render;
            end
            CMD_READ: begin
                o_result.read_data = rd_data;
            end
            CMD_WRITE: begin
                unique case (i_item.reg_offset)
                    OFS_LCDC: n_lcdc = i_item.write_data;
                    OFS_STAT: n_stat = i_item.write_data & STAT_WMASK;
                    OFS_LY:   n_line = 8'd0;
                    OFS_LYC:  n_lyc  = i_item.write_data;
                    default: begin
                        if (slot.hit) begin
                            n_plain[slot.idx] = i_item.write_data;
                        end
                    end
                endcase
            end
            default: ;
        endcase

        o_result.mode_now = n_mode;
        o_result.line_now = n_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc  <= LCDC_RESET;
            r_stat  <= STAT_RESET;
            r_line  <= 8'd0;
            r_lyc   <= 8'd0;
            r_mode  <= MODE_OAM;
            r_accum <= '0;
            for (int i = 0; i < PLAIN_DEPTH; i++) begin
                r_plain[i] <= 8'd0;
            end
        end else if (i_step) begin
            r_lcdc  <= n_lcdc;
            r_stat  <= n_stat;
            r_line  <= n_line;
            r_lyc   <= n_lyc;
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_plain <= n_plain;
        end
    end

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line <= LAST_LINE)
        else $error("line counter beyond last line");

    a_active_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != MODE_VBLANK |-> r_line < VBLANK_FIRST)
        else $error("visible mode on a vblank line");

    a_accum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_item.command != CMD_TICK) |=> r_accum == $past(r_accum))
        else $error("clock accumulator moved on a bus access");

endmodule

// ----- design/lcd_mode_timing_controller_unit.sv -----
// Top level of the LCD mode/line timing controller with its register file.
//
// i_in takes one transaction per item: a tick with an 8-bit clock count, a register
// read or a register write (offsets 0..15 from the LCDC address). o_out gives
// one result transaction per item: read data, frame ready, STAT interrupt and
// render pulses, and the mode and line after the item.
// Each item is held in an input register, runs through the combinational timing and
// register logic and lands in a result register, from which o_out offers it.
// One item per cycle is sustained while o_out is ready; the accumulate, compare
// and subtract are combinational.
// When o_out stalls, one more item is still taken into the input register;
// after that i_in.ready drops until the result is taken. No item is lost.
// Reset (synchronous, active low) empties both registers and loads LCDC 0x91,
// STAT 0x02, mode OAM scan, line 0 and clears the accumulator and registers.
`timescale 1ns / 1ps

module lcd_mode_timing_controller_unit import lmtc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lmtc_stream_if.sink   i_in,
    lmtc_stream_if.source o_out
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      adv;
    logic      step;
    t_out_item result;

    assign adv        = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && adv;
    assign i_in.ready = !r_in_valid || adv;

    lmtc_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    a_render_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.render_line |-> r_out_item.mode_now == MODE_HBLANK)
        else $error("render pulse outside hblank entry");

    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed item left no result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_item))
        else $error("stalled result transaction changed");

endmodule

// ----- bench/lcd_mode_timing_controller_unit_tb.sv -----
// Testbench for the LCD mode/line timing controller: directed and random traffic checked by a scoreboard.
`timescale 1ns / 1ps

module lcd_mode_timing_controller_unit_tb;
    import lmtc_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;

    class lcd_timing_scoreboard;
        logic [7:0]         lcdc;
        logic [7:0]         stat;
        logic [7:0]         ly;
        logic [7:0]         lyc;
        logic [1:0]         mode;
        logic [ACCUM_W-1:0] accum;
        logic [7:0]         misc_regs [PLAIN_DEPTH];
        logic               vbl_frame;
        int unsigned        clamps;
        int unsigned        errors;
        t_out_item          expected_q[$];

        function new();
            lcdc = LCDC_RESET;
            stat = STAT_RESET;
            ly = '0;
            lyc = '0;
            mode = MODE_OAM;
            accum = '0;
            foreach (misc_regs[i]) misc_regs[i] = '0;
            vbl_frame = 1'b0;
            clamps = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int misc_index(logic [3:0] ofs);
            case (ofs)
                OFS_SCY:  return 0;
                OFS_SCX:  return 1;
                OFS_BGP:  return 2;
                OFS_OBP0: return 3;
                OFS_OBP1: return 4;
                OFS_WY:   return 5;
                OFS_WX:   return 6;
                default:  return -1;
            endcase
        endfunction

        function void enter_mode(logic [1:0] m);
            mode = m;
            stat[1:0] = m;
        endfunction

        function void step_timing(logic [7:0] n, inout t_out_item r);
            logic [ACCUM_W:0] sum;
            sum = {1'b0, accum} + (ACCUM_W + 1)'(n);
            if (sum > {1'b0, ACCUM_MAX}) begin
                accum = ACCUM_MAX;
                clamps++;
            end else begin
                accum = sum[ACCUM_W-1:0];
            end
            if (!lcdc[LCDC_ON_BIT]) begin
                if (accum >= FRAME_CLOCKS) begin
                    accum -= FRAME_CLOCKS;
                    r.frame_ready = 1'b1;
                end
                return;
            end
            vbl_frame = 1'b0;
            case (mode)
                MODE_OAM: begin
                    if (accum >= OAM_CLOCKS) begin
                        accum -= OAM_CLOCKS;
                        enter_mode(MODE_DRAW);
                    end
                end
                MODE_DRAW: begin
                    if (accum >= DRAW_CLOCKS) begin
                        accum -= DRAW_CLOCKS;
                        r.render_line = 1'b1;
                        enter_mode(MODE_HBLANK);
                        if (stat[STAT_HBL_IE_BIT]) r.stat_irq_raised = 1'b1;
                    end
                end
                MODE_HBLANK: begin
                    if (accum >= HBLANK_CLOCKS) begin
                        accum -= HBLANK_CLOCKS;
                        ly = ly + 8'd1;
                        if (ly == lyc) begin
                            stat[STAT_COIN_BIT] = 1'b1;
                            if (stat[STAT_LYC_IE_BIT]) r.stat_irq_raised = 1'b1;
                        end else begin
                            stat[STAT_COIN_BIT] = 1'b0;
                        end
                        if (ly == VBLANK_FIRST) begin
                            enter_mode(MODE_VBLANK);
                            if (stat[STAT_VBL_IE_BIT]) r.stat_irq_raised = 1'b1;
                            vbl_frame = 1'b1;
                        end else begin
                            enter_mode(MODE_OAM);
                            if (stat[STAT_OAM_IE_BIT]) r.stat_irq_raised = 1'b1;
                        end
                    end
                end
                default: begin
                    if (accum >= LINE_CLOCKS) begin
                        accum -= LINE_CLOCKS;
                        ly = ly + 8'd1;
                        if (ly > LAST_LINE) begin
                            ly = '0;
                            enter_mode(MODE_OAM);
                            if (stat[STAT_OAM_IE_BIT]) r.stat_irq_raised = 1'b1;
                        end
                    end
                end
            endcase
            r.frame_ready = vbl_frame;
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            int        idx;
            r = '0;
            idx = misc_index(it.reg_offset);
            case (it.command)
                CMD_TICK: step_timing(it.clocks, r);
                CMD_READ: begin
                    case (it.reg_offset)
                        OFS_LCDC: r.read_data = lcdc;
                        OFS_STAT: r.read_data = stat;
                        OFS_LY:   r.read_data = ly;
                        OFS_LYC:  r.read_data = lyc;
                        default:  r.read_data = (idx >= 0) ? misc_regs[idx] : UNMAPPED_RD;
                    endcase
                end
                CMD_WRITE: begin
                    case (it.reg_offset)
                        OFS_LCDC: lcdc = it.write_data;
                        OFS_STAT: stat = it.write_data & STAT_WMASK;
                        OFS_LY:   ly = '0;
                        OFS_LYC:  lyc = it.write_data;
                        default:  if (idx >= 0) misc_regs[idx] = it.write_data;
                    endcase
                end
                default: ;
            endcase
            r.mode_now = mode;
            r.line_now = ly;
            expected_q.push_back(r);
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $error("result transaction with none expected");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare("read_data", want.read_data, got.read_data);
            compare("frame_ready", 8'(want.frame_ready), 8'(got.frame_ready));
            compare("stat_irq_raised", 8'(want.stat_irq_raised), 8'(got.stat_irq_raised));
            compare("render_line", 8'(want.render_line), 8'(got.render_line));
            compare("mode_now", 8'(want.mode_now), 8'(got.mode_now));
            compare("line_now", want.line_now, got.line_now);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;

    lcd_timing_scoreboard sb;

    lmtc_stream_if #(.t_payload(t_in_item))  in_if ();
    lmtc_stream_if #(.t_payload(t_out_item)) out_if ();

    lcd_mode_timing_controller_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    task automatic set_idling(int unsigned k);
        case (k % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 48; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 48; end
            default: begin src_idle_pct = 26; snk_stall_pct = 26; end
        endcase
    endtask

    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.data = it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(it);
    endtask

    task automatic send_cmd(logic [1:0] cmd, logic [7:0] n, logic [3:0] ofs, logic [7:0] d);
        t_in_item it;
        it.command = cmd;
        it.clocks = n;
        it.reg_offset = ofs;
        it.write_data = d;
        send_item(it);
    endtask

    task automatic tick(logic [7:0] n);
        send_cmd(CMD_TICK, n, 4'($urandom), 8'($urandom));
    endtask

    task automatic rd(logic [3:0] ofs);
        send_cmd(CMD_READ, 8'($urandom), ofs, 8'($urandom));
    endtask

    task automatic wr(logic [3:0] ofs, logic [7:0] d);
        send_cmd(CMD_WRITE, 8'($urandom), ofs, d);
    endtask

    task automatic run_directed();
        rd(OFS_LCDC);
        rd(OFS_STAT);
        rd(4'd6);
        rd(4'd15);
        wr(OFS_SCY, 8'hFF);
        rd(OFS_SCY);
        wr(OFS_WX, 8'h00);
        wr(4'd12, 8'hAA);
        rd(4'd12);
        tick(8'd0);
        tick(8'd255);
        tick(8'd255);
        wr(OFS_STAT, 8'hFF);        // mode and coincidence bits read back as zero
        rd(OFS_STAT);
        tick(8'd255);
        wr(OFS_LYC, 8'd2);
        repeat (3) tick(8'd255);
        wr(OFS_LY, 8'h5A);          // any data clears the line
        rd(OFS_LY);
        send_cmd(CMD_NOP, 8'hFF, 4'hF, 8'hFF);
        wr(OFS_LCDC, 8'h00);
        tick(8'd255);
        wr(OFS_LCDC, LCDC_RESET);
    endtask

    task automatic send_random_item();
        int unsigned pick;
        logic [7:0]  d;
        logic [3:0]  ofs;
        pick = $urandom_range(99);
        d = 8'($urandom);
        ofs = 4'($urandom);
        if (pick < 30) begin
            tick(8'($urandom));
        end else if (pick < 55) begin
            tick(8'($urandom_range(255, 180)));
        end else if (pick < 70) begin
            rd(ofs);
        end else if (pick < 95) begin
            if (ofs == OFS_LCDC && $urandom_range(3) != 0) d[LCDC_ON_BIT] = 1'b1;
            if (ofs == OFS_LYC && $urandom_range(1) != 0) d = sb.ly + 8'($urandom_range(3));
            wr(ofs, d);
        end else begin
            send_cmd(CMD_NOP, 8'($urandom), ofs, d);
        end
    endtask

    // Wind the off-display frame counter to its top, switch on and run
    // full frames with heavy ticks until the accumulator has saturated four times.
    task automatic run_frame_sweep();
        int unsigned n;
        int unsigned pick;
        n = 0;
        set_idling(0);
        wr(OFS_LCDC, 8'h11);
        while (32'(sb.accum) + 32'd255 < 32'(FRAME_CLOCKS)) begin
            tick(8'd255);
            if ($urandom_range(15) == 0) rd(4'($urandom));
            n++;
            if (n % 60 == 0) set_idling(n / 60);
        end
        tick(8'(32'(FRAME_CLOCKS) - 32'd1 - 32'(sb.accum)));
        wr(OFS_LCDC, 8'($urandom) | 8'h80);
        wr(OFS_STAT, 8'($urandom));
        wr(OFS_LYC, 8'($urandom_range(153)));
        while (sb.clamps < 4) begin
            pick = $urandom_range(31);
            if (pick == 0) begin
                wr(OFS_STAT, 8'($urandom));
            end else if (pick == 1) begin
                wr(OFS_LYC, ($urandom_range(1) != 0) ? 8'($urandom_range(153, 140))
                                                    : 8'($urandom_range(153)));
            end else if (pick == 2) begin
                rd(4'($urandom));
            end else begin
                tick(8'($urandom_range(255, 236)));
            end
            n++;
            if (n % 150 == 0) set_idling(n / 150);
        end
        repeat (10) tick(8'd255);
    endtask

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready = !(snk_stall_pct != 0 && $urandom_range(99) < snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready) sb.check_result(out_if.data);
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        sb = new();
        in_if.valid = 1'b0;
        in_if.data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        run_directed();
        for (int k = 0; k < 4; k++) begin
            set_idling(k);
            repeat (60) send_random_item();
        end
        run_frame_sweep();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        snk_stall_pct = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
